FILE: rtl/mbrot_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel core package
// Register map, reset values and the microprogram of the iteration sequencer.
// ----------------------------------------------------------------------------
package mbrot_pkg;

  // Configuration register map (byte address 4*i).
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_ORIGIN_REAL = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IMAG = 2'd1;
  localparam logic [1:0] REG_PIXEL_STEP  = 2'd2;
  localparam logic [1:0] REG_ITER_LIMIT  = 2'd3;

  localparam int STEP_W = 29;

  localparam logic signed [31:0]  ORIGIN_REAL_RESET = -32'sd570425344;
  localparam logic signed [31:0]  ORIGIN_IMAG_RESET = -32'sd402653184;
  localparam logic [STEP_W-1:0]   PIXEL_STEP_RESET  = 29'd1006633;
  localparam logic [15:0]         ITER_LIMIT_RESET  = 16'd1024;

  localparam logic [7:0] SHADE_MAX = 8'd255;

  // Sequencer program counter.
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t PC_IDLE      = 4'd0;
  localparam upc_t PC_COORD     = 4'd1;
  localparam upc_t PC_ORIGIN    = 4'd2;
  localparam upc_t PC_TEST      = 4'd3;
  localparam upc_t PC_SQ_A      = 4'd4;
  localparam upc_t PC_SQ_B      = 4'd5;
  localparam upc_t PC_CROSS     = 4'd6;
  localparam upc_t PC_UPDATE    = 4'd7;
  localparam upc_t PC_DIV_INIT  = 4'd8;
  localparam upc_t PC_DIV_STEP  = 4'd9;
  localparam upc_t PC_EMIT      = 4'd10;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_COORD,
    OP_ORIGIN,
    OP_TEST,
    OP_SQ_A,
    OP_SQ_B,
    OP_CROSS,
    OP_UPDATE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_START,
    C_STOP,
    C_ESCAPE,
    C_DIV_LOOP
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } uword_t;

  // The control store. A jump is taken when its condition holds, otherwise
  // the sequencer falls through to the next step.
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:     w = '{op: OP_WAIT,     cond: C_WAIT_START, target: PC_IDLE};
      PC_COORD:    w = '{op: OP_COORD,    cond: C_NEXT,       target: PC_IDLE};
      PC_ORIGIN:   w = '{op: OP_ORIGIN,   cond: C_NEXT,       target: PC_IDLE};
      PC_TEST:     w = '{op: OP_TEST,     cond: C_STOP,       target: PC_DIV_INIT};
      PC_SQ_A:     w = '{op: OP_SQ_A,     cond: C_NEXT,       target: PC_IDLE};
      PC_SQ_B:     w = '{op: OP_SQ_B,     cond: C_NEXT,       target: PC_IDLE};
      PC_CROSS:    w = '{op: OP_CROSS,    cond: C_ESCAPE,     target: PC_DIV_INIT};
      PC_UPDATE:   w = '{op: OP_UPDATE,   cond: C_JUMP,       target: PC_TEST};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,       target: PC_IDLE};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_LOOP,   target: PC_DIV_STEP};
      PC_EMIT:     w = '{op: OP_EMIT,     cond: C_JUMP,       target: PC_IDLE};
      default:     w = '{op: OP_WAIT,     cond: C_JUMP,       target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/mandelbrot_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// One pixel per command; each iteration runs the test, two squares, the cross product
// and the update on one shared multiplier. Once the limit is reached, a component
// exceeds 2 or |z|^2 exceeds 4, a shade divide runs and the result strobe follows.
// Busy falls in the cycle after the strobe, so a new command is taken only once the
// pixel is done; the receiver cannot stall the core.
// Synchronous reset returns the sequencer to idle and loads register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core #(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 16,
  parameter int FRAC_BITS  = 28
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [COORD_BITS-1:0]        pixel_row,
  input  logic [COORD_BITS-1:0]        pixel_col,
  // result channel
  output logic                         done,
  output logic [7:0]                   shade,
  output logic [15:0]                  iter_count,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbrot_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mbrot_pkg::*;

  localparam int LIM_W  = (ITER_BITS < 16) ? ITER_BITS : 16;
  localparam int PC_W   = STEP_W + COORD_BITS;
  localparam int CW     = PC_W + 2;
  localparam int ZW     = ((CW > FRAC_BITS + 4) ? CW : FRAC_BITS + 4) + 1;
  localparam int MW     = FRAC_BITS + 2;
  localparam int PW     = 2 * MW;
  localparam int DW     = LIM_W + 8;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(ITER_LIMIT_RESET);
  localparam logic [ZW-1:0]    BOUND       = ZW'(1) << (FRAC_BITS + 1);
  localparam logic [PW:0]      FOUR_SQ     = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  // configuration registers
  logic signed [31:0]  origin_real;
  logic signed [31:0]  origin_imag;
  logic [STEP_W-1:0]   pixel_step;
  logic [LIM_W-1:0]    iteration_limit;

  // sequencer
  upc_t   pc;
  upc_t   pc_next;
  uword_t uw;
  logic   taken;

  // datapath
  logic [COORD_BITS-1:0] row_r;
  logic [COORD_BITS-1:0] col_r;
  logic [PC_W-1:0]       prod_col;
  logic [PC_W-1:0]       prod_row;
  logic signed [CW-1:0]  cr;
  logic signed [CW-1:0]  ci;
  logic signed [CW-1:0]  cr_next;
  logic signed [CW-1:0]  ci_next;
  logic signed [ZW-1:0]  za;
  logic signed [ZW-1:0]  zb;
  logic [ZW-1:0]         ma_full;
  logic [ZW-1:0]         mb_full;
  logic [MW-1:0]         ma;
  logic [MW-1:0]         mb;
  logic                  sign_diff;
  logic [MW-1:0]         mul_x;
  logic [MW-1:0]         mul_y;
  logic [PW-1:0]         mul_p;
  logic [PW-1:0]         a2;
  logic [PW-1:0]         b2;
  logic [PW-1:0]         ab;
  logic signed [PW:0]    diff;
  logic signed [PW+1:0]  cross2;
  logic signed [PW+1:0]  cross_s;
  logic [LIM_W-1:0]      k;
  logic                  stop_cond;
  logic                  escape;
  logic [DW-1:0]         rem;
  logic [DW-1:0]         dvs;
  logic [2:0]            dcnt;
  logic [7:0]            quo;
  logic                  div_ge;
  logic                  cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real     <= ORIGIN_REAL_RESET;
      origin_imag     <= ORIGIN_IMAG_RESET;
      pixel_step      <= PIXEL_STEP_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ORIGIN_REAL: origin_real     <= $signed(pwdata);
        REG_ORIGIN_IMAG: origin_imag     <= $signed(pwdata);
        REG_PIXEL_STEP:  pixel_step      <= pwdata[STEP_W-1:0];
        REG_ITER_LIMIT:  iteration_limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORIGIN_REAL: prdata = origin_real;
      REG_ORIGIN_IMAG: prdata = origin_imag;
      REG_PIXEL_STEP:  prdata = 32'(pixel_step);
      REG_ITER_LIMIT:  prdata = 32'(iteration_limit);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign uw   = ucode_rom(pc);
  assign busy = (pc != PC_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    case (uw.cond)
      C_NEXT:       taken = 1'b0;
      C_JUMP:       taken = 1'b1;
      C_WAIT_START: taken = ~start;
      C_STOP:       taken = stop_cond;
      C_ESCAPE:     taken = escape;
      C_DIV_LOOP:   taken = (dcnt != 3'd0);
      default:      taken = 1'b1;
    endcase
    pc_next = taken ? uw.target : pc + upc_t'(1);
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign cr_next = CW'(origin_real) + $signed(CW'(prod_col));
  assign ci_next = CW'(origin_imag) + $signed(CW'(prod_row));

  assign ma_full = za[ZW-1] ? (~za + ZW'(1)) : za;
  assign mb_full = zb[ZW-1] ? (~zb + ZW'(1)) : zb;

  // Large components count as an escape before any square is formed.
  assign stop_cond = (k >= iteration_limit) || (ma_full > BOUND) || (mb_full > BOUND);

  // One shared multiplier; the step selects the operands.
  assign mul_x = (uw.op == OP_SQ_B) ? mb : ma;
  assign mul_y = (uw.op == OP_SQ_A) ? ma : mb;
  assign mul_p = mul_x * mul_y;

  assign escape  = ((PW + 1)'(a2) + (PW + 1)'(b2)) > FOUR_SQ;
  assign diff    = $signed({1'b0, a2}) - $signed({1'b0, b2});
  assign cross2  = $signed({1'b0, ab, 1'b0});
  assign cross_s = sign_diff ? -cross2 : cross2;
  assign div_ge  = (rem >= dvs);

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_WAIT: begin
        row_r <= pixel_row;
        col_r <= pixel_col;
      end
      OP_COORD: begin
        prod_col <= pixel_step * col_r;
        prod_row <= pixel_step * row_r;
      end
      OP_ORIGIN: begin
        cr <= cr_next;
        ci <= ci_next;
        za <= ZW'(cr_next);
        zb <= ZW'(ci_next);
        k  <= '0;
      end
      OP_TEST: begin
        ma        <= ma_full[MW-1:0];
        mb        <= mb_full[MW-1:0];
        sign_diff <= za[ZW-1] ^ zb[ZW-1];
      end
      OP_SQ_A:  a2 <= mul_p;
      OP_SQ_B:  b2 <= mul_p;
      OP_CROSS: ab <= mul_p;
      OP_UPDATE: begin
        za <= ZW'(diff >>> FRAC_BITS) + ZW'(cr);
        zb <= ZW'(cross_s >>> FRAC_BITS) + ZW'(ci);
        k  <= k + LIM_W'(1);
      end
      OP_DIV_INIT: begin
        // k*255 as k*256 - k; the quotient fits eight bits since k <= limit.
        rem  <= DW'({k, 8'b0}) - DW'(k);
        dvs  <= DW'({iteration_limit, 7'b0});
        dcnt <= 3'd7;
        quo  <= '0;
      end
      OP_DIV_STEP: begin
        if (div_ge) begin
          rem <= rem - dvs;
        end
        quo  <= {quo[6:0], div_ge};
        dvs  <= dvs >> 1;
        dcnt <= dcnt - 3'd1;
      end
      OP_EMIT: ;
      default: ;
    endcase
  end

  assign done       = (uw.op == OP_EMIT);
  assign shade      = (iteration_limit == '0) ? SHADE_MAX : SHADE_MAX - quo;
  assign iter_count = 16'(k);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while sequencer idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> (iter_count <= 16'(iteration_limit)))
    else $error("iteration count above the limit");

  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    (done && (iteration_limit == '0)) |-> (shade == SHADE_MAX && iter_count == 16'd0))
    else $error("zero limit gave a wrong result word");

endmodule
